### hdl/pfpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_pkg: shared types and constants
// Command codes, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package pfpc_pkg;
	localparam int RING_DEPTH_DEF    = 5;
	localparam int FRACTION_BITS_DEF = 8;

	localparam logic [1:0] CMD_SELECT = 2'd0;
	localparam logic [1:0] CMD_PLAY   = 2'd1;
	localparam logic [1:0] CMD_VOLUME = 2'd2;
	localparam logic [1:0] CMD_PAUSE  = 2'd3;

	localparam logic [2:0] REG_MAX_VOLUME    = 3'd0;
	localparam logic [2:0] REG_FADE_IN_STEP  = 3'd1;
	localparam logic [2:0] REG_FADE_OUT_STEP = 3'd2;
	localparam logic [2:0] REG_ON_THRESHOLD  = 3'd3;
	localparam logic [2:0] REG_OFF_THRESHOLD = 3'd4;
	localparam logic [2:0] REG_RELEASE_COUNT = 3'd5;
	localparam logic [2:0] REG_PLAY_TICKS    = 3'd6;
	localparam logic [2:0] REG_HOLD_TICKS    = 3'd7;

	localparam int CFG_DATA_W = 17;

	// Classified measurement handed from the front part to the sequencer.
	typedef struct packed {
		logic present;
		logic idle;
	} pfpc_evt_t;

	typedef struct packed {
		logic [1:0] command;
		logic [4:0] volume;
		logic       present;
		logic       last;
	} pfpc_out_t;
endpackage

### hdl/pfpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_in_if / pfpc_out_if: valid/ready channels
// Input measurement channel and player command channel.
// ----------------------------------------------------------------------------
interface pfpc_in_if;
	logic       valid;
	logic       ready;
	logic [9:0] lit_first;
	logic [9:0] lit_second;
	logic [9:0] dark_sample;
	logic       player_idle;
	modport source (output valid, lit_first, lit_second, dark_sample, player_idle,
		input ready);
	modport sink (input valid, lit_first, lit_second, dark_sample, player_idle,
		output ready);
endinterface

interface pfpc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [4:0] volume;
	logic       present;
	logic       last;
	modport source (output valid, command, volume, present, last, input ready);
	modport sink (input valid, command, volume, present, last, output ready);
endinterface

### hdl/pfpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_front: measurement filter and presence detector
// Rings, sequential medians, averages, hysteresis and release debounce.
// ----------------------------------------------------------------------------
module pfpc_front #(
	parameter int RING_DEPTH    = pfpc_pkg::RING_DEPTH_DEF,
	parameter int FRACTION_BITS = pfpc_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [9:0]          lit_first,
	input  logic [9:0]          lit_second,
	input  logic [9:0]          dark_sample,
	input  logic                player_idle,
	input  logic [16:0]         on_threshold,
	input  logic [16:0]         off_threshold,
	input  logic [7:0]          release_count,
	output logic                evt_valid,
	input  logic                evt_ready,
	output pfpc_pkg::pfpc_evt_t evt
);
	localparam int SW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int AW  = 17 + FRACTION_BITS;
	localparam int TW  = 17 + FRACTION_BITS;
	localparam int MID = RING_DEPTH / 2;

	// Reciprocal of ten scaled by 2^23, rounded up. The shifted product is the
	// exact quotient for every 20-bit lit product.
	localparam logic [19:0] RECIP_TEN = 20'd838861;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PROD = 3'd1;
	localparam logic [2:0] ST_RANK = 3'd2;
	localparam logic [2:0] ST_AVG  = 3'd3;
	localparam logic [2:0] ST_BASE = 3'd4;
	localparam logic [2:0] ST_DET  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]  state_q;
	logic [16:0] lit_ring_q [RING_DEPTH];
	logic [9:0]  dark_ring_q [RING_DEPTH];
	logic [SW-1:0] slot_q, cand_q;
	logic [19:0] prod_q;
	logic [9:0]  dk_q;
	logic        idle_q;
	logic [16:0] lit_med_q;
	logic [9:0]  dark_med_q;
	logic [AW-1:0] lit_avg_q, dark_avg_q, base_q;
	logic        raw_q, pres_q;
	logic [7:0]  rel_q;

	logic [39:0] tenth;
	assign tenth = 40'(prod_q) * 40'(RECIP_TEN);

	// Rank of the candidate: an entry is the median (upper middle) when exactly
	// MID entries sort strictly before it. Stable ordering by index breaks ties.
	logic [SW:0] lit_lt, dark_lt;
	always_comb begin
		lit_lt  = '0;
		dark_lt = '0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (lit_ring_q[i] < lit_ring_q[cand_q] ||
				(lit_ring_q[i] == lit_ring_q[cand_q] && SW'(i) < cand_q))
				lit_lt = lit_lt + 1'b1;
			if (dark_ring_q[i] < dark_ring_q[cand_q] ||
				(dark_ring_q[i] == dark_ring_q[cand_q] && SW'(i) < cand_q))
				dark_lt = dark_lt + 1'b1;
		end
	end

	logic [AW:0] lit_sum, dark_sum, base_sum;
	assign lit_sum  = {1'b0, lit_avg_q} + ((AW+1)'(lit_med_q) << FRACTION_BITS);
	assign dark_sum = {1'b0, dark_avg_q} + ((AW+1)'(dark_med_q) << FRACTION_BITS);
	assign base_sum = {1'b0, base_q} + (AW+1)'(lit_avg_q - dark_avg_q);

	logic [TW-1:0] on_t, off_t;
	assign on_t  = TW'(on_threshold) << FRACTION_BITS;
	assign off_t = TW'(off_threshold) << FRACTION_BITS;

	logic raw_n;
	assign raw_n = (base_q > on_t) ? 1'b1 : (base_q < off_t) ? 1'b0 : raw_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign evt_valid = (state_q == ST_OUT);
	assign evt.present = pres_q;
	assign evt.idle    = idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < RING_DEPTH; i++) begin
				lit_ring_q[i]  <= '0;
				dark_ring_q[i] <= '0;
			end
			slot_q <= '0; cand_q <= '0;
			lit_avg_q <= '0; dark_avg_q <= '0; base_q <= '0;
			raw_q <= 1'b0; pres_q <= 1'b0; rel_q <= '0;
			lit_med_q <= '0; dark_med_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prod_q  <= lit_first * lit_second;
						dk_q    <= dark_sample;
						idle_q  <= player_idle;
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					lit_ring_q[slot_q]  <= tenth[39:23];
					dark_ring_q[slot_q] <= dk_q;
					slot_q  <= (32'(slot_q) + 1 >= RING_DEPTH) ? '0 : slot_q + 1'b1;
					cand_q  <= '0;
					state_q <= ST_RANK;
				end
				ST_RANK: begin
					if (lit_lt == (SW+1)'(MID)) lit_med_q <= lit_ring_q[cand_q];
					if (dark_lt == (SW+1)'(MID)) dark_med_q <= dark_ring_q[cand_q];
					if (32'(cand_q) == RING_DEPTH - 1) state_q <= ST_AVG;
					else cand_q <= cand_q + 1'b1;
				end
				ST_AVG: begin
					lit_avg_q  <= lit_sum[AW:1];
					dark_avg_q <= dark_sum[AW:1];
					state_q    <= ST_BASE;
				end
				ST_BASE: begin
					if (lit_avg_q > dark_avg_q) base_q <= base_sum[AW:1];
					else if (dark_avg_q > lit_avg_q) base_q <= base_q >> 1;
					state_q <= ST_DET;
				end
				ST_DET: begin
					raw_q <= raw_n;
					if (raw_n) begin
						pres_q <= 1'b1;
						rel_q  <= '0;
					end else if ({1'b0, rel_q} + 9'd1 > {1'b0, release_count}) begin
						pres_q <= 1'b0;
						rel_q  <= '0;
					end else begin
						rel_q <= rel_q + 8'd1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (evt_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hdl/pfpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_queue: two-entry event queue
// Decouples the detector from the command sequencer.
// ----------------------------------------------------------------------------
module pfpc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  pfpc_pkg::pfpc_evt_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output pfpc_pkg::pfpc_evt_t rd_data
);
	pfpc_pkg::pfpc_evt_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### hdl/pfpc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_seq: player command sequencer
// Plans up to five commands per event and sends them one word at a time.
// ----------------------------------------------------------------------------
module pfpc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_ready,
	input  pfpc_pkg::pfpc_evt_t evt,
	input  logic [4:0]          max_volume,
	input  logic [4:0]          fade_in_step,
	input  logic [4:0]          fade_out_step,
	input  logic [7:0]          play_ticks,
	input  logic [7:0]          hold_ticks,
	output logic                out_valid,
	input  logic                out_ready,
	output pfpc_pkg::pfpc_out_t out_word
);
	logic       playing_q;
	logic [7:0] timer_q, hold_q;
	logic [5:0] level_q;
	logic [2:0] left_q;
	logic [1:0] cmd_q [5];
	logic [4:0] vol_q;
	logic       pres_q;
	logic [2:0] ptr_q;

	// Plan for one event.
	logic       play_n, strt1, strt2, fin;
	logic [7:0] timer_n, hold_n;
	logic [5:0] level_n;
	logic [6:0] up, dn;
	logic [1:0] fcmd;
	logic [2:0] cnt;
	logic [1:0] plan [5];
	always_comb begin
		play_n  = playing_q;
		timer_n = timer_q;
		hold_n  = hold_q;
		level_n = level_q;
		strt1 = 1'b0; strt2 = 1'b0; fin = 1'b0;
		up = 7'(level_q) + 7'(fade_in_step);
		dn = 7'(level_q) - 7'(fade_out_step);
		fcmd = pfpc_pkg::CMD_VOLUME;
		if (evt.present) begin
			if (!playing_q) begin
				play_n = 1'b1;
				timer_n = '0;
				strt1 = evt.idle;
			end
			hold_n = '0;
			if (timer_n < play_ticks) begin
				fin = 1'b1;
				timer_n = timer_n + 8'd1;
				strt2 = evt.idle;
				level_n = (up > 7'(max_volume)) ? 6'(max_volume) : up[5:0];
			end else if (dn[6] || dn == 7'd0) begin
				level_n = 6'd1;
				fcmd = pfpc_pkg::CMD_PAUSE;
			end else begin
				level_n = dn[5:0];
			end
		end else begin
			play_n = 1'b0;
			if (hold_q > hold_ticks) timer_n = '0;
			else if (hold_q != 8'hFF) hold_n = hold_q + 8'd1;
			if (dn[6] || dn == 7'd0) begin
				level_n = 6'd1;
				fcmd = pfpc_pkg::CMD_PAUSE;
			end else begin
				level_n = dn[5:0];
			end
		end
		for (int i = 0; i < 5; i++) plan[i] = pfpc_pkg::CMD_SELECT;
		cnt = 3'd0;
		if (strt1) begin
			plan[0] = pfpc_pkg::CMD_SELECT; plan[1] = pfpc_pkg::CMD_PLAY; cnt = 3'd2;
		end
		if (strt2) begin
			plan[cnt] = pfpc_pkg::CMD_SELECT; plan[cnt + 3'd1] = pfpc_pkg::CMD_PLAY;
			cnt = cnt + 3'd2;
		end
		plan[cnt] = fin ? pfpc_pkg::CMD_VOLUME : fcmd;
		cnt = cnt + 3'd1;
	end

	assign evt_ready = (left_q == 3'd0);
	assign out_valid = (left_q != 3'd0);
	assign out_word.command = cmd_q[ptr_q];
	assign out_word.volume  = (cmd_q[ptr_q] == pfpc_pkg::CMD_VOLUME) ? vol_q : 5'd0;
	assign out_word.present = pres_q;
	assign out_word.last    = (left_q == 3'd1);

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			for (int i = 0; i < 5; i++) cmd_q[i] <= plan[i];
			vol_q  <= level_n[4:0];
			pres_q <= evt.present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0; timer_q <= '0; hold_q <= '0; level_q <= 6'd1;
			left_q <= '0; ptr_q <= '0;
		end else if (evt_valid && evt_ready) begin
			playing_q <= play_n; timer_q <= timer_n; hold_q <= hold_n;
			level_q <= level_n; left_q <= cnt; ptr_q <= '0;
		end else if (out_valid && out_ready) begin
			left_q <= left_q - 3'd1;
			ptr_q  <= ptr_q + 3'd1;
		end
	end
endmodule

### hdl/proximity_fade_player_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_fade_player_control: presence-driven player fade controller
// Each measurement word on "in" (two lit conversions, one dark conversion
// and the player idle bit) is filtered through median rings and running
// averages, turned into a debounced presence flag, and then drives a
// sequencer that sends one to five player command words on "out". The
// last word of each measurement carries last = 1.
// The front filter takes one word at a time through product, median search
// (one ring entry ranked per cycle), averages, baseline and detection, then
// hands the event on and raises in.ready again. The sequencer sends one word
// per cycle while out.ready is high and picks up the next measurement once
// the last word is taken. A two-entry queue sits between them, so the filter
// takes new measurements while commands are still waiting on a stalled
// receiver; when the queue fills, in.ready stays low. Reset clears the
// control state and rings and loads the register defaults. The user must
// write registers through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module proximity_fade_player_control #(
	parameter int RING_DEPTH    = pfpc_pkg::RING_DEPTH_DEF,
	parameter int FRACTION_BITS = pfpc_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pfpc_in_if.sink                       in,
	pfpc_out_if.source                    out,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [pfpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	// Configuration registers.
	logic [4:0]  max_volume_q, fade_in_q, fade_out_q;
	logic [16:0] on_thr_q, off_thr_q;
	logic [7:0]  release_q, play_ticks_q, hold_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_volume_q <= 5'd20; fade_in_q <= 5'd5; fade_out_q <= 5'd2;
			on_thr_q <= 17'd150; off_thr_q <= 17'd50; release_q <= 8'd5;
			play_ticks_q <= 8'd160; hold_ticks_q <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				pfpc_pkg::REG_MAX_VOLUME:    max_volume_q <= cfg_data[4:0];
				pfpc_pkg::REG_FADE_IN_STEP:  fade_in_q    <= cfg_data[4:0];
				pfpc_pkg::REG_FADE_OUT_STEP: fade_out_q   <= cfg_data[4:0];
				pfpc_pkg::REG_ON_THRESHOLD:  on_thr_q     <= cfg_data;
				pfpc_pkg::REG_OFF_THRESHOLD: off_thr_q    <= cfg_data;
				pfpc_pkg::REG_RELEASE_COUNT: release_q    <= cfg_data[7:0];
				pfpc_pkg::REG_PLAY_TICKS:    play_ticks_q <= cfg_data[7:0];
				pfpc_pkg::REG_HOLD_TICKS:    hold_ticks_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Front filter to queue, queue to sequencer.
	logic                f_valid, f_ready, q_valid, q_ready;
	pfpc_pkg::pfpc_evt_t f_evt, q_evt;
	pfpc_pkg::pfpc_out_t word;

	pfpc_front #(.RING_DEPTH(RING_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready),
		.lit_first(in.lit_first), .lit_second(in.lit_second),
		.dark_sample(in.dark_sample), .player_idle(in.player_idle),
		.on_threshold(on_thr_q), .off_threshold(off_thr_q),
		.release_count(release_q),
		.evt_valid(f_valid), .evt_ready(f_ready), .evt(f_evt)
	);

	pfpc_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_evt),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_evt)
	);

	pfpc_seq u_seq (
		.clk, .arst_n,
		.evt_valid(q_valid), .evt_ready(q_ready), .evt(q_evt),
		.max_volume(max_volume_q), .fade_in_step(fade_in_q),
		.fade_out_step(fade_out_q), .play_ticks(play_ticks_q),
		.hold_ticks(hold_ticks_q),
		.out_valid(out.valid), .out_ready(out.ready), .out_word(word)
	);

	assign out.command = word.command;
	assign out.volume  = word.volume;
	assign out.present = word.present;
	assign out.last    = word.last;
endmodule

### hdl/pfpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_checker: port-level checks
// Checks command words and handshake behavior at the top level.
// ----------------------------------------------------------------------------
module pfpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] command,
	input logic [4:0] volume,
	input logic       last
);
	a_vol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command != pfpc_pkg::CMD_VOLUME |-> volume == 5'd0)
		else $error("volume set on a non-volume command");
	a_play_after_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && command == pfpc_pkg::CMD_SELECT |=>
		out_valid && command == pfpc_pkg::CMD_PLAY)
		else $error("select not followed by play");
	a_select_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == pfpc_pkg::CMD_SELECT |-> !last)
		else $error("select marked last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command))
		else $error("stalled word changed");
endmodule

bind proximity_fade_player_control pfpc_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out.valid), .out_ready(out.ready),
	.command(out.command), .volume(out.volume), .last(out.last)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for proximity_fade_player_control
// A short directed table of measurement words is sent first, then random
// words that mostly form presence episodes (a strong lit signal for a while,
// then a dark stretch). Every command word is checked field by field against
// an in-bench model of the filter, the debounce and the fade sequencer.
// Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	localparam int DEPTH = pfpc_pkg::RING_DEPTH_DEF;
	localparam int FRAC  = pfpc_pkg::FRACTION_BITS_DEF;
	localparam int LIMIT = 2000000;

	// One directed row: the measurement word, plus an optional typed-in
	// expectation for the first command word it causes.
	typedef struct {
		logic [9:0] lit_a;
		logic [9:0] lit_b;
		logic [9:0] dark;
		logic       idle;
		logic       has_typed;
		logic [1:0] typed_cmd;
		logic [4:0] typed_vol;
	} meas_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [pfpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	pfpc_in_if  meas_ch ();
	pfpc_out_if cmd_ch ();

	proximity_fade_player_control dut (
		.clk(clk), .arst_n(arst_n), .in(meas_ch.sink), .out(cmd_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Model copy of the registers.
	logic [4:0]  m_max_vol, m_in_step, m_out_step;
	logic [16:0] m_on_thr, m_off_thr;
	logic [7:0]  m_rel_cnt, m_play_ticks, m_hold_ticks;

	// Model copy of the filter and sequencer state.
	logic [16:0] m_lit_ring [DEPTH];
	logic [9:0]  m_dark_ring [DEPTH];
	int unsigned m_slot;
	logic [63:0] m_lit_avg, m_dark_avg, m_baseline;
	logic        m_raw, m_presence, m_playing;
	int unsigned m_rel_ctr, m_play_timer, m_hold_ctr;
	int          m_level;

	pfpc_pkg::pfpc_out_t pending_cmds [$];
	pfpc_pkg::pfpc_out_t first_cmd;
	int errors = 0;
	int words_sent = 0;
	int cmds_seen = 0;
	int cycles = 0;
	int sent_ready_gaps = 1;

	task automatic report(input string what, input logic [8:0] got, input logic [8:0] want);
		$display("ERROR at cmd word %0d: %s got %0h want %0h", cmds_seen, what, got, want);
		errors++;
	endtask

	function automatic int unsigned median_of(input int unsigned v [DEPTH]);
		int unsigned t [DEPTH];
		int unsigned x;
		int j;
		t = v;
		for (int i = 1; i < DEPTH; i++) begin
			x = t[i];
			j = i;
			while (j > 0 && t[j-1] > x) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = x;
		end
		return t[DEPTH/2];
	endfunction

	task automatic model_reset();
		m_max_vol = 20; m_in_step = 5; m_out_step = 2;
		m_on_thr = 150; m_off_thr = 50; m_rel_cnt = 5;
		m_play_ticks = 160; m_hold_ticks = 10;
		for (int i = 0; i < DEPTH; i++) begin
			m_lit_ring[i] = '0;
			m_dark_ring[i] = '0;
		end
		m_slot = 0;
		m_lit_avg = 0; m_dark_avg = 0; m_baseline = 0;
		m_raw = 0; m_presence = 0; m_playing = 0;
		m_rel_ctr = 0; m_play_timer = 0; m_hold_ctr = 0;
		m_level = 1;
	endtask

	// Queue one command word; volume only means something for set volume.
	task automatic push_cmd(inout pfpc_pkg::pfpc_out_t list [$], input logic [1:0] c,
			input int v);
		pfpc_pkg::pfpc_out_t w;
		w.command = c;
		w.volume = (c == pfpc_pkg::CMD_VOLUME) ? 5'(v) : 5'd0;
		w.present = 1'b0;
		w.last = 1'b0;
		list.push_back(w);
	endtask

	// Advance the model by one measurement and append its command words.
	task automatic predict_commands(input logic [9:0] a, input logic [9:0] b,
			input logic [9:0] dk, input logic idle);
		int unsigned lv [DEPTH];
		int unsigned dv [DEPTH];
		logic [63:0] lmed, dmed;
		pfpc_pkg::pfpc_out_t step_cmds [$];
		m_lit_ring[m_slot] = 17'((32'(a) * 32'(b)) / 32'd10);
		m_dark_ring[m_slot] = dk;
		m_slot = (m_slot + 1 >= DEPTH) ? 0 : m_slot + 1;
		for (int i = 0; i < DEPTH; i++) begin
			lv[i] = m_lit_ring[i];
			dv[i] = m_dark_ring[i];
		end
		lmed = median_of(lv);
		dmed = median_of(dv);
		m_lit_avg = (m_lit_avg + (lmed << FRAC)) >> 1;
		m_dark_avg = (m_dark_avg + (dmed << FRAC)) >> 1;
		if (m_lit_avg > m_dark_avg)
			m_baseline = (m_baseline + (m_lit_avg - m_dark_avg)) >> 1;
		else if (m_dark_avg > m_lit_avg)
			m_baseline = m_baseline >> 1;
		// The on test comes first, so crossed thresholds favor detection.
		if (m_baseline > (64'(m_on_thr) << FRAC))
			m_raw = 1;
		else if (m_baseline < (64'(m_off_thr) << FRAC))
			m_raw = 0;
		if (m_raw) begin
			m_presence = 1;
			m_rel_ctr = 0;
		end else if (m_rel_ctr + 1 > m_rel_cnt) begin
			m_rel_ctr = 0;
			m_presence = 0;
			m_playing = 0;
		end else begin
			m_rel_ctr = m_rel_ctr + 1;
		end
		if (m_presence) begin
			if (!m_playing) begin
				m_playing = 1;
				m_play_timer = 0;
				if (idle) begin
					push_cmd(step_cmds, pfpc_pkg::CMD_SELECT, 0);
					push_cmd(step_cmds, pfpc_pkg::CMD_PLAY, 0);
				end
			end
			m_hold_ctr = 0;
			if (m_play_timer < m_play_ticks) begin
				m_play_timer++;
				if (idle) begin
					push_cmd(step_cmds, pfpc_pkg::CMD_SELECT, 0);
					push_cmd(step_cmds, pfpc_pkg::CMD_PLAY, 0);
				end
				m_level = m_level + int'(m_in_step);
				if (m_level > int'(m_max_vol)) m_level = int'(m_max_vol);
				push_cmd(step_cmds, pfpc_pkg::CMD_VOLUME, m_level);
			end else begin
				m_level = m_level - int'(m_out_step);
				if (m_level < 1) begin
					m_level = 1;
					push_cmd(step_cmds, pfpc_pkg::CMD_PAUSE, 0);
				end else begin
					push_cmd(step_cmds, pfpc_pkg::CMD_VOLUME, m_level);
				end
			end
		end else begin
			m_level = m_level - int'(m_out_step);
			// The hold counter saturates, so hold_ticks 255 never clears the timer.
			if (m_hold_ctr > m_hold_ticks) m_play_timer = 0;
			else if (m_hold_ctr < 255) m_hold_ctr++;
			if (m_level < 1) begin
				m_playing = 0;
				m_level = 1;
				push_cmd(step_cmds, pfpc_pkg::CMD_PAUSE, 0);
			end else begin
				push_cmd(step_cmds, pfpc_pkg::CMD_VOLUME, m_level);
			end
		end
		for (int k = 0; k < step_cmds.size(); k++) begin
			step_cmds[k].present = m_presence;
			step_cmds[k].last = (k == step_cmds.size() - 1);
			pending_cmds.push_back(step_cmds[k]);
		end
		first_cmd = step_cmds[0];
	endtask

	// Gap length: mostly zero or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Send one measurement word, predicting at the accepting edge. Valid
	// stays high into the next word unless a gap follows.
	task automatic send_word(input logic [9:0] a, input logic [9:0] b,
			input logic [9:0] dk, input logic idle);
		int g;
		g = sent_ready_gaps ? gap_len() : 0;
		if (g > 0) begin
			meas_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		meas_ch.valid <= 1'b1;
		meas_ch.lit_first <= a;
		meas_ch.lit_second <= b;
		meas_ch.dark_sample <= dk;
		meas_ch.player_idle <= idle;
		do @(posedge clk); while (!meas_ch.ready);
		predict_commands(a, b, dk, idle);
		words_sent++;
		@(negedge clk);
	endtask

	// Wait until every expected command word has arrived, then let the
	// filter settle before touching registers.
	task automatic drain();
		meas_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= pfpc_pkg::CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pfpc_pkg::REG_MAX_VOLUME:    m_max_vol = 5'(val);
			pfpc_pkg::REG_FADE_IN_STEP:  m_in_step = 5'(val);
			pfpc_pkg::REG_FADE_OUT_STEP: m_out_step = 5'(val);
			pfpc_pkg::REG_ON_THRESHOLD:  m_on_thr = 17'(val);
			pfpc_pkg::REG_OFF_THRESHOLD: m_off_thr = 17'(val);
			pfpc_pkg::REG_RELEASE_COUNT: m_rel_cnt = 8'(val);
			pfpc_pkg::REG_PLAY_TICKS:    m_play_ticks = 8'(val);
			pfpc_pkg::REG_HOLD_TICKS:    m_hold_ticks = 8'(val);
			default: ;
		endcase
	endtask

	task automatic write_all(input int mv, input int fi, input int fo, input int on,
			input int off, input int rc, input int pt, input int ht);
		write_reg(pfpc_pkg::REG_MAX_VOLUME, mv);
		write_reg(pfpc_pkg::REG_FADE_IN_STEP, fi);
		write_reg(pfpc_pkg::REG_FADE_OUT_STEP, fo);
		write_reg(pfpc_pkg::REG_ON_THRESHOLD, on);
		write_reg(pfpc_pkg::REG_OFF_THRESHOLD, off);
		write_reg(pfpc_pkg::REG_RELEASE_COUNT, rc);
		write_reg(pfpc_pkg::REG_PLAY_TICKS, pt);
		write_reg(pfpc_pkg::REG_HOLD_TICKS, ht);
	endtask

	// Random episodes: a presence burst of strong lit words, then a dark
	// stretch of low lit words, with some plain noise words mixed in.
	task automatic random_phase(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(3, 25);
			for (int i = 0; i < burst && left > 0; i++, left--) begin
				if ($urandom_range(0, 9) == 0)
					send_word(10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom));
				else
					send_word(10'($urandom_range(600, 1023)),
						10'($urandom_range(600, 1023)),
						10'($urandom_range(0, 300)), 1'($urandom));
			end
			burst = $urandom_range(3, 20);
			for (int i = 0; i < burst && left > 0; i++, left--) begin
				send_word(10'($urandom_range(0, 100)), 10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)), 1'($urandom));
			end
		end
	endtask

	// Receiver: random stalls on ready, check on every accepted word.
	initial begin
		pfpc_pkg::pfpc_out_t want;
		int g;
		cmd_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				cmd_ch.ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			cmd_ch.ready <= 1'b1;
			@(posedge clk);
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmds_seen++;
				if (pending_cmds.size() == 0) begin
					report("unexpected word", {cmd_ch.command, cmd_ch.volume,
						cmd_ch.present, cmd_ch.last}, 9'h0);
				end else begin
					want = pending_cmds.pop_front();
					if (cmd_ch.command !== want.command)
						report("command", 9'(cmd_ch.command), 9'(want.command));
					if (cmd_ch.volume !== want.volume)
						report("volume", 9'(cmd_ch.volume), 9'(want.volume));
					if (cmd_ch.present !== want.present)
						report("present", 9'(cmd_ch.present), 9'(want.present));
					if (cmd_ch.last !== want.last)
						report("last", 9'(cmd_ch.last), 9'(want.last));
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("proximity_fade_player_control: mismatch");
			$finish;
		end
	end

	// Directed table. A typed expectation covers only the first row:
	// after reset a dark word fades from level 1 to pause.
	meas_row_t rows [] = '{
		'{10'd0, 10'd0, 10'd0, 1'b0, 1'b1, pfpc_pkg::CMD_PAUSE, 5'd0},
		'{10'd1023, 10'd1023, 10'd0, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd1023, 10'd1023, 10'd0, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd1023, 10'd1023, 10'd0, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd1023, 10'd1023, 10'd0, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd1023, 10'd1023, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd1023, 10'd1023, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd0, 10'd1023, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd0, 10'd1023, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd0, 10'd1023, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd0, 10'd1023, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd0, 10'd0, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd0, 10'd0, 10'd0, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd512, 10'd512, 10'd512, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd341, 10'd682, 10'd341, 1'b0, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0},
		'{10'd682, 10'd341, 10'd682, 1'b1, 1'b0, pfpc_pkg::CMD_SELECT, 5'd0}
	};

	initial begin
		meas_ch.valid = 1'b0;
		meas_ch.lit_first = '0;
		meas_ch.lit_second = '0;
		meas_ch.dark_sample = '0;
		meas_ch.player_idle = 1'b0;
		model_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		foreach (rows[r]) begin
			send_word(rows[r].lit_a, rows[r].lit_b, rows[r].dark, rows[r].idle);
			if (rows[r].has_typed && (first_cmd.command !== rows[r].typed_cmd
					|| first_cmd.volume !== rows[r].typed_vol))
				report("directed table", {first_cmd.command, first_cmd.volume, 2'b0},
					{rows[r].typed_cmd, rows[r].typed_vol, 2'b0});
		end
		// Sender holds off until every expected word has come.
		drain();

		// Phase settings: defaults, then extremes and mid values.
		random_phase(60);
		drain();
		write_all(30, 30, 30, 0, 0, 0, 0, 0);
		random_phase(40);
		drain();
		write_all(1, 0, 1, 131071, 131071, 255, 255, 255);
		random_phase(30);
		drain();
		// Crossed thresholds: on below off.
		write_all(25, 3, 0, 20, 2000, 2, 12, 3);
		random_phase(50);
		drain();
		write_all($urandom_range(1, 30), $urandom_range(0, 30), $urandom_range(1, 30),
			$urandom_range(0, 3000), $urandom_range(0, 1000), $urandom_range(0, 10),
			$urandom_range(0, 40), $urandom_range(0, 20));
		random_phase(100);
		drain();

		$display("sent %0d measurement words, checked %0d command words", words_sent,
			cmds_seen);
		$display("covered five register settings including both extremes");
		if (errors == 0 && pending_cmds.size() == 0)
			$display("proximity_fade_player_control: match");
		else
			$display("proximity_fade_player_control: mismatch");
		$finish;
	end
endmodule
